// File: hdl/i2c_slave_write_receiver_core_assert.svh
// assertion macros shared by the receiver modules
// the enclosing module must provide clk and arst_n
`ifndef I2C_SLAVE_WRITE_RECEIVER_CORE_ASSERT_SVH
`define I2C_SLAVE_WRITE_RECEIVER_CORE_ASSERT_SVH

// condition implies consequence in the same cycle
`define I2CWR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// condition implies consequence in the next cycle
`define I2CWR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

// File: hdl/i2cwr_pkg.sv
package i2cwr_pkg;

	// register indexes of the configuration port
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDRESS    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BUS_FREE_TICKS = 1'b1;

	// reset values of the registers
	localparam logic [6:0] OWN_ADDRESS_RESET    = 7'd34;
	localparam logic [7:0] BUS_FREE_TICKS_RESET = 8'd5;

	// one line sample
	typedef struct packed {
		logic scl_level;
		logic sda_level;
	} sample_t;

	// one result item
	typedef struct packed {
		logic       sda_pull_low;
		logic       byte_valid;
		logic [7:0] data_byte;
		logic       addressed;
	} result_t;

	// configuration seen by the state machine
	typedef struct packed {
		logic [6:0] own_address;
		logic [7:0] bus_free_ticks;
	} cfg_t;

endpackage

// File: hdl/i2cwr_ifs.sv
// line sample channel
interface i2cwr_sample_if;
	logic valid;
	logic ready;
	logic scl_level;
	logic sda_level;
	modport source (output valid, output scl_level, output sda_level, input ready);
	modport sink (input valid, input scl_level, input sda_level, output ready);
endinterface

// result channel
interface i2cwr_result_if;
	logic       valid;
	logic       ready;
	logic       sda_pull_low;
	logic       byte_valid;
	logic [7:0] data_byte;
	logic       addressed;
	modport source (output valid, output sda_pull_low, output byte_valid,
		output data_byte, output addressed, input ready);
	modport sink (input valid, input sda_pull_low, input byte_valid,
		input data_byte, input addressed, output ready);
endinterface

// configuration write channel
interface i2cwr_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [i2cwr_pkg::CFG_IDX_W-1:0]    index;
	logic [7:0]                         data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: hdl/i2cwr_fsm.sv
module i2cwr_fsm (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  i2cwr_pkg::sample_t sample,
	input  i2cwr_pkg::cfg_t    cfg,
	output i2cwr_pkg::result_t res
);

	`include "i2c_slave_write_receiver_core_assert.svh"

	// bus phases
	localparam logic [2:0] PH_FREE    = 3'd0;
	localparam logic [2:0] PH_START   = 3'd1;
	localparam logic [2:0] PH_LOWWAIT = 3'd2;
	localparam logic [2:0] PH_BITS    = 3'd3;
	localparam logic [2:0] PH_ACK     = 3'd4;

	// sub-steps of one bit clock
	localparam logic [1:0] SUB_WAIT_HIGH = 2'd0;
	localparam logic [1:0] SUB_ONE_BIT   = 2'd1;
	localparam logic [1:0] SUB_ZERO_BIT  = 2'd2;

	logic [2:0] phase_q, phase_d;
	logic [7:0] free_q, free_d;
	logic [3:0] bc_q, bc_d;
	logic [7:0] shift_q, shift_d;
	logic [1:0] sub_q, sub_d;
	logic       last_sda_q;
	logic       in_data_q, in_data_d;

	logic       scl, sda;
	logic       bit_done, stop_seen;
	logic [3:0] bc_inc;

	assign scl    = sample.scl_level;
	assign sda    = sample.sda_level;
	assign bc_inc = bc_q + 4'd1;

	// next state and result for one sample
	always_comb begin
		phase_d          = phase_q;
		free_d           = free_q;
		bc_d             = bc_q;
		shift_d          = shift_q;
		sub_d            = sub_q;
		in_data_d        = in_data_q;
		bit_done         = 1'b0;
		stop_seen        = 1'b0;
		res.sda_pull_low = 1'b0;
		res.byte_valid   = 1'b0;
		res.data_byte    = 8'd0;
		unique case (phase_q)
			PH_FREE: begin
				if (scl && sda) begin
					if (free_q <= 8'd1) phase_d = PH_START;
					else free_d = free_q - 8'd1;
				end else begin
					free_d = cfg.bus_free_ticks;
				end
			end
			PH_START: begin
				if (scl && !sda && last_sda_q) phase_d = PH_LOWWAIT;
			end
			PH_LOWWAIT: begin
				if (!scl && !sda) begin
					phase_d = PH_BITS;
					bc_d    = 4'd0;
					shift_d = 8'd0;
					sub_d   = SUB_WAIT_HIGH;
				end
			end
			PH_BITS: begin
				// sample on scl high, end of bit on scl low, stop after a zero bit
				if (sub_q == SUB_ONE_BIT) begin
					if (!scl) bit_done = 1'b1;
				end else if (sub_q == SUB_ZERO_BIT) begin
					if (!scl) bit_done = 1'b1;
					else if (sda) stop_seen = 1'b1;
				end else if (scl) begin
					shift_d = {shift_q[6:0], sda};
					sub_d   = sda ? SUB_ONE_BIT : SUB_ZERO_BIT;
				end
				if (stop_seen) begin
					phase_d   = PH_FREE;
					free_d    = cfg.bus_free_ticks;
					in_data_d = 1'b0;
					bc_d      = 4'd0;
					sub_d     = SUB_WAIT_HIGH;
				end else if (bit_done) begin
					sub_d = SUB_WAIT_HIGH;
					bc_d  = bc_inc;
					if (bc_inc[3]) begin
						bc_d = 4'd0;
						if (in_data_q || shift_q == {cfg.own_address, 1'b0}) begin
							phase_d          = PH_ACK;
							res.sda_pull_low = 1'b1;
						end else begin
							phase_d   = PH_FREE;
							free_d    = cfg.bus_free_ticks;
							in_data_d = 1'b0;
						end
					end
				end
			end
			PH_ACK: begin
				if (sub_q == SUB_ONE_BIT) begin
					if (!scl) begin
						if (in_data_q) begin
							res.byte_valid = 1'b1;
							res.data_byte  = shift_q;
						end
						in_data_d = 1'b1;
						phase_d   = PH_BITS;
						bc_d      = 4'd0;
						sub_d     = SUB_WAIT_HIGH;
					end else begin
						res.sda_pull_low = 1'b1;
					end
				end else begin
					if (scl) sub_d = SUB_ONE_BIT;
					res.sda_pull_low = 1'b1;
				end
			end
			default: begin
				phase_d   = PH_FREE;
				free_d    = cfg.bus_free_ticks;
				in_data_d = 1'b0;
				bc_d      = 4'd0;
				sub_d     = SUB_WAIT_HIGH;
			end
		endcase
		res.addressed = in_data_d;
	end

	// state registers, advanced once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_FREE;
			free_q     <= i2cwr_pkg::BUS_FREE_TICKS_RESET;
			bc_q       <= 4'd0;
			shift_q    <= 8'd0;
			sub_q      <= SUB_WAIT_HIGH;
			last_sda_q <= 1'b1;
			in_data_q  <= 1'b0;
		end else if (step) begin
			phase_q    <= phase_d;
			free_q     <= free_d;
			bc_q       <= bc_d;
			shift_q    <= shift_d;
			sub_q      <= sub_d;
			last_sda_q <= sda;
			in_data_q  <= in_data_d;
		end
	end

	// a reported byte only comes from the data phase
	`I2CWR_ASSERT_NOW(a_valid_addressed, res.byte_valid, res.addressed && in_data_q)
	// acknowledge is driven only around a byte boundary
	`I2CWR_ASSERT_NOW(a_pull_phase, res.sda_pull_low, phase_q == PH_BITS || phase_q == PH_ACK)
	// end of the acknowledge clock enters the data phase
	`I2CWR_ASSERT_NEXT(a_ack_enters_data,
		step && phase_q == PH_ACK && sub_q == SUB_ONE_BIT && !scl,
		in_data_q && phase_q == PH_BITS)

endmodule

// File: hdl/i2c_slave_write_receiver_core.sv
// channel   dir   payload                                           handshake
// sample    in    scl_level, sda_level                              valid/ready
// result    out   sda_pull_low, byte_valid, data_byte, addressed    valid/ready
// cfg       in    index, data                                       valid/ready
//
// one item per cycle sustained while the sink keeps result.ready high; a result
// is offered from the result register after its sample is accepted into the input
// register, and the whole line state machine step sits between those two registers
// arst_n clears state; registers return to address 34 and 5 bus-free ticks
// a result held back by the sink stalls the input stage, so sample.ready falls
// only while both stages are full and result.ready is low
module i2c_slave_write_receiver_core (
	input  logic            clk,
	input  logic            arst_n,
	i2cwr_sample_if.sink    sample,
	i2cwr_result_if.source  result,
	i2cwr_cfg_if.sink       cfg
);

	logic [6:0]          own_address_q;
	logic [7:0]          bus_free_q;
	i2cwr_pkg::cfg_t     cfg_cur;

	logic                valid_s1;
	i2cwr_pkg::sample_t  sample_s1;
	logic                out_valid_q;
	i2cwr_pkg::result_t  result_q;
	i2cwr_pkg::result_t  res_d;
	logic                adv;
	logic                step;

	// configuration registers, writes always taken
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q <= i2cwr_pkg::OWN_ADDRESS_RESET;
			bus_free_q    <= i2cwr_pkg::BUS_FREE_TICKS_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				i2cwr_pkg::REG_OWN_ADDRESS:    own_address_q <= cfg.data[6:0];
				i2cwr_pkg::REG_BUS_FREE_TICKS: bus_free_q    <= cfg.data;
				default: ;
			endcase
		end
	end
	assign cfg_cur.own_address    = own_address_q;
	assign cfg_cur.bus_free_ticks = bus_free_q;

	// pipeline flow control
	assign adv          = !out_valid_q || result.ready;
	assign step         = valid_s1 && adv;
	assign sample.ready = !valid_s1 || adv;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end
	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid) begin
			sample_s1.scl_level <= sample.scl_level;
			sample_s1.sda_level <= sample.sda_level;
		end
	end

	// line state machine
	i2cwr_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.sample (sample_s1),
		.cfg    (cfg_cur),
		.res    (res_d)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (step) result_q <= res_d;
	end

	assign result.valid        = out_valid_q;
	assign result.sda_pull_low = result_q.sda_pull_low;
	assign result.byte_valid   = result_q.byte_valid;
	assign result.data_byte    = result_q.data_byte;
	assign result.addressed    = result_q.addressed;

endmodule
